@@ rtl/bee_pkg.sv @@
package bee_pkg;

	// Deepest nesting of open operator frames.
	localparam int MAX_NESTING = 32;
	// Address width of the frame memory and width of the nesting level.
	localparam int ADDR_W = $clog2(MAX_NESTING);
	localparam int LVL_W  = $clog2(MAX_NESTING + 1);

	// Characters with a meaning of their own.
	localparam logic [7:0] CH_AND     = 8'h26; // '&'
	localparam logic [7:0] CH_OR      = 8'h7C; // '|'
	localparam logic [7:0] CH_NOT     = 8'h21; // '!'
	localparam logic [7:0] CH_CLOSE   = 8'h29; // ')'
	localparam logic [7:0] CH_FALSE   = 8'h66; // 'f'
	localparam logic [7:0] CH_LOWER_A = 8'h61; // 'a'
	localparam logic [7:0] CH_LOWER_Z = 8'h7A; // 'z'
	localparam logic [7:0] CH_UPPER_A = 8'h41; // 'A'
	localparam logic [7:0] CH_UPPER_Z = 8'h5A; // 'Z'

	typedef enum logic [1:0] {
		OP_AND = 2'd0,
		OP_OR  = 2'd1,
		OP_NOT = 2'd2
	} bee_op_t;

	typedef logic [ADDR_W-1:0] bee_addr_t;
	typedef logic [LVL_W-1:0]  bee_level_t;

	// One stack frame: its operator and running value.
	typedef struct packed {
		bee_op_t op;
		logic    acc;
	} bee_frame_t;

	// Result handed from the evaluator to the output register.
	typedef struct packed {
		logic valid;
		logic value;
		logic error;
	} bee_result_t;

	// Evaluator status seen by the top level.
	typedef struct packed {
		logic       busy;
		bee_level_t level;
	} bee_status_t;

	// Folds a value into a frame accumulator according to its operator.
	function automatic logic bee_fold(bee_op_t op, logic acc, logic v);
		logic r;
		unique case (op)
			OP_AND:  r = acc & v;
			OP_OR:   r = acc | v;
			default: r = v;
		endcase
		return r;
	endfunction

	// True for A-Z and a-z.
	function automatic logic bee_is_letter(logic [7:0] ch);
		return ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z)) ||
			((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z));
	endfunction

endpackage

@@ rtl/bee_frame_mem.sv @@
module bee_frame_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  bee_pkg::bee_addr_t  wr_addr,
	input  bee_pkg::bee_frame_t wr_data,
	input  bee_pkg::bee_addr_t  rd_addr,
	output bee_pkg::bee_frame_t rd_data
);

	bee_pkg::bee_frame_t frame_mem [bee_pkg::MAX_NESTING];
	bee_pkg::bee_frame_t rd_data_q;
	bee_pkg::bee_frame_t byp_data_q;
	logic                byp_hit_q;

	// Single write port, one registered read port, read-first in the array itself.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_mem[wr_addr] <= wr_data;
		end
		rd_data_q  <= frame_mem[rd_addr];
		byp_data_q <= wr_data;
	end

	// A write and a read of the same entry in one cycle forward the new data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_hit_q <= 1'b0;
		end else begin
			byp_hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_hit_q ? byp_data_q : rd_data_q;

endmodule

@@ rtl/bee_core.sv @@
module bee_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic [7:0]           symbol,
	input  logic                 last_symbol,
	input  logic                 out_space,
	output bee_pkg::bee_result_t res,
	output bee_pkg::bee_status_t status
);

	typedef enum logic [1:0] {
		ST_RUN    = 2'b01,
		ST_UNWIND = 2'b10
	} bee_state_t;

	bee_state_t          state_q, state_d;
	bee_pkg::bee_level_t level_q, level_d;
	logic                top_val_q, top_val_d;
	logic                err_q, err_d;
	bee_pkg::bee_op_t    top_op_q, top_op_d;
	logic                top_acc_q, top_acc_d;

	logic                wr_en;
	bee_pkg::bee_addr_t  wr_addr;
	bee_pkg::bee_frame_t wr_data;
	bee_pkg::bee_addr_t  rd_addr;
	bee_pkg::bee_frame_t below;

	logic                pop_v;
	logic                pop_acc;
	logic                lit;
	bee_pkg::bee_op_t    new_op;
	logic                is_op;

	// The frame under the top one, always read at the address that the next level needs.
	bee_frame_mem u_frame_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (below)
	);

	// Closing the top frame yields its value, folded into the frame below.
	assign pop_v   = top_acc_q ^ (top_op_q == bee_pkg::OP_NOT);
	assign pop_acc = bee_pkg::bee_fold(below.op, below.acc, pop_v);
	assign lit     = (symbol != bee_pkg::CH_FALSE);

	// Operator decode.
	always_comb begin
		is_op  = 1'b1;
		new_op = bee_pkg::OP_AND;
		priority if (symbol == bee_pkg::CH_AND) begin
			new_op = bee_pkg::OP_AND;
		end else if (symbol == bee_pkg::CH_OR) begin
			new_op = bee_pkg::OP_OR;
		end else if (symbol == bee_pkg::CH_NOT) begin
			new_op = bee_pkg::OP_NOT;
		end else begin
			is_op = 1'b0;
		end
	end

	// Next-state logic: one character per cycle while step_en is set, then one frame per cycle while unwinding.
	always_comb begin
		state_d   = state_q;
		level_d   = level_q;
		top_val_d = top_val_q;
		err_d     = err_q;
		top_op_d  = top_op_q;
		top_acc_d = top_acc_q;
		wr_en     = 1'b0;
		wr_addr   = bee_pkg::bee_addr_t'(level_q - 1'b1);
		wr_data   = '{op: top_op_q, acc: top_acc_q};
		res       = '0;
		unique case (state_q)
			ST_RUN: begin
				if (step_en) begin
					priority if (bee_pkg::bee_is_letter(symbol)) begin
						if (level_q == '0) begin
							top_val_d = lit;
						end else begin
							top_acc_d = bee_pkg::bee_fold(top_op_q, top_acc_q, lit);
						end
					end else if (is_op) begin
						if (level_q == bee_pkg::bee_level_t'(bee_pkg::MAX_NESTING)) begin
							err_d = 1'b1;
						end else begin
							// The old top frame moves into memory.
							wr_en     = (level_q != '0);
							top_op_d  = new_op;
							top_acc_d = (new_op != bee_pkg::OP_OR);
							level_d   = level_q + 1'b1;
						end
					end else if (symbol == bee_pkg::CH_CLOSE) begin
						if (level_q == '0) begin
							err_d = 1'b1;
						end else begin
							level_d = level_q - 1'b1;
							if (level_q == bee_pkg::bee_level_t'(1)) begin
								top_val_d = pop_v;
							end else begin
								top_op_d  = below.op;
								top_acc_d = pop_acc;
							end
						end
					end else begin
						// Any other character leaves the stack as it is.
					end
					if (last_symbol) begin
						if (level_d == '0) begin
							res.valid = 1'b1;
							res.value = top_val_d;
							res.error = err_d;
							top_val_d = 1'b0;
							err_d     = 1'b0;
						end else begin
							state_d = ST_UNWIND;
						end
					end
				end
			end
			ST_UNWIND: begin
				if (level_q != '0) begin
					level_d = level_q - 1'b1;
					if (level_q == bee_pkg::bee_level_t'(1)) begin
						top_val_d = pop_v;
					end else begin
						top_op_d  = below.op;
						top_acc_d = pop_acc;
					end
				end else if (out_space) begin
					res.valid = 1'b1;
					res.value = top_val_q;
					res.error = err_q;
					top_val_d = 1'b0;
					err_d     = 1'b0;
					state_d   = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	assign rd_addr = bee_pkg::bee_addr_t'(level_d - bee_pkg::bee_level_t'(2));

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RUN;
			level_q   <= '0;
			top_val_q <= 1'b0;
			err_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			level_q   <= level_d;
			top_val_q <= top_val_d;
			err_q     <= err_d;
		end
	end

	// Top frame, held in registers.
	always_ff @(posedge clk) begin
		top_op_q  <= top_op_d;
		top_acc_q <= top_acc_d;
	end

	assign status.busy  = (state_q == ST_UNWIND);
	assign status.level = level_q;

endmodule

@@ rtl/boolean_expression_evaluator.sv @@
// Timing: an item without the last mark produces no result. A last item puts its result in the
// output register in the cycle after acceptance when no frame is open; else the frames still
// open are closed one per cycle through the frame memory read port before the result is written.
// Throughput: one item per cycle; last items wait for output room; input stalls while unwinding.
// Reset: arst_n clears the nesting level, top-level value, error flag and output valid at once;
// the frame memory is not cleared, and only entries below the nesting level are ever used.
module boolean_expression_evaluator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] symbol,
	input  logic       last_symbol,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       value,
	output logic       error
);

	bee_pkg::bee_result_t res;
	bee_pkg::bee_status_t status;
	logic                 out_valid_q;
	logic                 value_q;
	logic                 error_q;
	logic                 out_space;
	logic                 step_en;

	// A last item needs room in the output register; other items never wait for it.
	assign out_space = !out_valid_q || out_ready;
	assign in_ready  = !status.busy && (out_space || !last_symbol);
	assign step_en   = in_valid && in_ready;

	bee_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (step_en),
		.symbol      (symbol),
		.last_symbol (last_symbol),
		.out_space   (out_space),
		.res         (res),
		.status      (status)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			value_q <= res.value;
			error_q <= res.error;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign error     = error_q;

`ifndef SYNTH
	// A new result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> out_space)
		else $error("result produced while output register is occupied");

	// The nesting level stays within the stack.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.level <= bee_pkg::bee_level_t'(bee_pkg::MAX_NESTING))
		else $error("nesting level beyond stack depth");

	// Unwinding closes exactly one frame per cycle.
	a_unwind_step: assert property (@(posedge clk) disable iff (!arst_n)
		(status.busy && (status.level != '0)) |=>
		(status.level == $past(status.level) - 1'b1))
		else $error("unwind did not close one frame");

	// Each result leaves the stack empty for the next expression.
	a_empty_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |=> (status.level == '0) && !status.busy)
		else $error("stack not empty after result");
`endif

endmodule
